/* rtl/b64enc_pkg.sv */
package b64enc_pkg;

  // ASCII anchors of the standard alphabet
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_PAD     = 8'h3D;

  // Sextet code boundaries
  localparam logic [5:0] SEXTET_LOWER = 6'd26;
  localparam logic [5:0] SEXTET_DIGIT = 6'd52;
  localparam logic [5:0] SEXTET_PLUS  = 6'd62;
  localparam logic [5:0] SEXTET_SLASH = 6'd63;

  // Bytes held while a group fills
  localparam logic [1:0] HELD_NONE = 2'd0;
  localparam logic [1:0] HELD_ONE  = 2'd1;
  localparam logic [1:0] HELD_TWO  = 2'd2;

  // Character slot of the group's final character
  localparam logic [1:0] SLOT_LAST = 2'd3;

  // One complete group handed from front to back
  typedef struct packed {
    logic [23:0] bits;      // three bytes, first byte in 23:16
    logic [1:0]  pad_count; // number of trailing '=' characters
    logic        last;      // group closes the message
  } group_t;

  // Map one 6-bit code to its ASCII character
  function automatic logic [7:0] sextet_to_char(input logic [5:0] code);
    logic [7:0] ch;
    if (code < SEXTET_LOWER) begin
      ch = CHAR_UPPER_A + {2'b00, code};
    end else if (code < SEXTET_DIGIT) begin
      ch = CHAR_LOWER_A + {2'b00, code - SEXTET_LOWER};
    end else if (code < SEXTET_PLUS) begin
      ch = CHAR_ZERO + {2'b00, code - SEXTET_DIGIT};
    end else if (code == SEXTET_PLUS) begin
      ch = CHAR_PLUS;
    end else begin
      ch = CHAR_SLASH;
    end
    return ch;
  endfunction

endpackage

/* rtl/base64_stream_encoder.sv */
// Streaming Base64 encoder, standard alphabet with '=' padding. Each input
// word carries one message byte and msg_end on its last byte. Every third byte,
// or the last byte of a message, closes a group that yields four characters;
// a short final group ends in "==" or "=". group_last marks the fourth
// character of each group, message_done the final character of the message.
// Bytes are taken one per cycle while the group queue (QUEUE_DEPTH groups)
// has room; characters leave one per cycle while out_stall is low, so four
// characters leave for every three bytes of a full group, and the
// single-character output register sets the sustained rate. When the queue is
// empty and the back end has no group in hand, a closed group is written to a
// queue slot, then loaded as the group in hand, then its first character is registered.
module base64_stream_encoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       msg_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       group_last,
  output logic       message_done
);
  import b64enc_pkg::*;

  group_t push_group;
  group_t head_group;
  logic   push;
  logic   pop;
  logic   q_full;
  logic   q_empty;

  b64enc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .msg_end    (msg_end),
    .q_full     (q_full),
    .push       (push),
    .push_group (push_group)
  );

  b64enc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_group (push_group),
    .pop        (pop),
    .head_group (head_group),
    .full       (q_full),
    .empty      (q_empty)
  );

  b64enc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_group   (head_group),
    .q_empty      (q_empty),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char     (out_char),
    .group_last   (group_last),
    .message_done (message_done)
  );

  // Never write a full queue
  assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("group pushed into full queue");

  // Never read an empty queue
  assert property (@(posedge clk) disable iff (rst) pop |-> !q_empty)
    else $error("group popped from empty queue");

  // Message end always falls on a group boundary
  assert property (@(posedge clk) disable iff (rst)
    out_valid && message_done |-> group_last)
    else $error("message_done outside group boundary");

  // A pushed group with the queue empty and the back idle shows up next cycle
  assert property (@(posedge clk) disable iff (rst)
    push && q_empty |=> !q_empty || pop)
    else $error("pushed group lost");

endmodule

/* rtl/b64enc_front.sv */
module b64enc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          data_byte,
  input  logic                msg_end,
  input  logic                q_full,
  output logic                push,
  output b64enc_pkg::group_t  push_group
);
  import b64enc_pkg::*;

  logic [1:0]  count;
  logic [1:0]  count_next;
  logic [15:0] held;
  logic [15:0] held_next;
  logic        accept;
  logic        complete;

  // Hold off new words while the queue has no room
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // A group closes on its third byte or on the message's last byte
  assign complete = (count >= HELD_TWO) || msg_end;
  assign push     = accept && complete;

  // Build the group word and its padding from the held bytes
  always_comb begin
    push_group.last = msg_end;
    case (count)
      HELD_NONE: begin
        push_group.bits      = {data_byte, 16'h0000};
        push_group.pad_count = 2'd2;
      end
      HELD_ONE: begin
        push_group.bits      = {held[15:8], data_byte, 8'h00};
        push_group.pad_count = 2'd1;
      end
      default: begin
        push_group.bits      = {held, data_byte};
        push_group.pad_count = 2'd0;
      end
    endcase
  end

  // Advance the pending count and store bytes of an open group
  always_comb begin
    count_next = count;
    held_next  = held;
    if (accept) begin
      if (complete) begin
        count_next = HELD_NONE;
        held_next  = 16'h0000;
      end else if (count == HELD_NONE) begin
        count_next = HELD_ONE;
        held_next  = {data_byte, 8'h00};
      end else begin
        count_next = HELD_TWO;
        held_next  = {held[15:8], data_byte};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= HELD_NONE;
      held  <= 16'h0000;
    end else begin
      count <= count_next;
      held  <= held_next;
    end
  end

endmodule

/* rtl/b64enc_queue.sv */
module b64enc_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  b64enc_pkg::group_t  push_group,
  input  logic                pop,
  output b64enc_pkg::group_t  head_group,
  output logic                full,
  output logic                empty
);
  import b64enc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

  group_t           slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] rd_ptr_next;
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] fill_next;

  assign full       = (fill == CNT_MAX);
  assign empty      = (fill == '0);
  assign head_group = slots[rd_ptr];

  // Advance pointers with wrap and track the fill level
  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    fill_next   = fill;
    if (push) begin
      wr_ptr_next = (wr_ptr == PTR_MAX) ? '0 : wr_ptr + 1'b1;
    end
    if (pop) begin
      rd_ptr_next = (rd_ptr == PTR_MAX) ? '0 : rd_ptr + 1'b1;
    end
    if (push && !pop) begin
      fill_next = fill + 1'b1;
    end else if (pop && !push) begin
      fill_next = fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      fill   <= fill_next;
    end
  end

  // Store the incoming group
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_group;
    end
  end

endmodule

/* rtl/b64enc_back.sv */
module b64enc_back (
  input  logic                clk,
  input  logic                rst,
  input  b64enc_pkg::group_t  head_group,
  input  logic                q_empty,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_char,
  output logic                group_last,
  output logic                message_done
);
  import b64enc_pkg::*;

  group_t     cur;
  logic       busy;
  logic       busy_next;
  logic [1:0] slot;
  logic [1:0] slot_next;
  logic       slot_free;
  logic       emit;
  logic       finish;
  logic [5:0] code;
  logic       is_pad;
  logic [7:0] char_now;

  // Output register takes a new word when empty or being drained
  assign slot_free = !out_valid || !out_stall;
  assign emit      = busy && slot_free;
  assign finish    = emit && (slot == SLOT_LAST);
  assign pop       = !q_empty && (!busy || finish);

  // Pick the sextet for the current slot, most significant first
  always_comb begin
    case (slot)
      2'd0:    code = cur.bits[23:18];
      2'd1:    code = cur.bits[17:12];
      2'd2:    code = cur.bits[11:6];
      default: code = cur.bits[5:0];
    endcase
  end

  // Trailing slots of a short group become pad characters
  assign is_pad   = ({1'b0, slot} + {1'b0, cur.pad_count}) > {1'b0, SLOT_LAST};
  assign char_now = is_pad ? CHAR_PAD : sextet_to_char(code);

  // Advance through the four slots of the group in hand
  always_comb begin
    busy_next = busy;
    slot_next = slot;
    if (pop) begin
      busy_next = 1'b1;
      slot_next = 2'd0;
    end else if (finish) begin
      busy_next = 1'b0;
    end else if (emit) begin
      slot_next = slot + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      slot      <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      busy <= busy_next;
      slot <= slot_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load the group in hand and the output word
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head_group;
    end
    if (emit) begin
      out_char     <= char_now;
      group_last   <= (slot == SLOT_LAST);
      message_done <= (slot == SLOT_LAST) && cur.last;
    end
  end

endmodule

/* tb/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import b64enc_pkg::*;

  // One message byte as offered to the block
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } msg_word_t;

  // One encoded character as it should leave the block
  typedef struct packed {
    logic [7:0] ch;
    logic       grp_last;
    logic       msg_done;
  } b64_char_t;

  localparam string B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam int LONG_HOLD_AT     = 60;
  localparam int LONG_HOLD_CYCLES = 120;
  localparam int DRAIN_CYCLES     = 20;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte = 8'h00;
  logic       msg_end = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_char;
  logic       group_last;
  logic       message_done;

  msg_word_t  tx_words[$];
  b64_char_t  expected_chars[$];

  // Encoder state as the testbench tracks it
  logic [1:0]  held_cnt = HELD_NONE;
  logic [15:0] held_bytes = 16'h0000;

  bit          quiet = 1'b0;
  int unsigned tx_idle_left = 0;
  int unsigned rx_idle_left = 0;
  int unsigned long_hold_left = 0;
  bit          long_hold_done = 1'b0;
  int unsigned chars_seen = 0;
  int unsigned mismatches = 0;

  base64_stream_encoder dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .msg_end      (msg_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char     (out_char),
    .group_last   (group_last),
    .message_done (message_done)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Fold one accepted byte into the group; queue four characters once it closes
  function automatic void encode_byte(input logic [7:0] b, input logic last);
    logic [23:0] grp;
    int          n_data;
    b64_char_t   c;
    if (held_cnt != HELD_TWO && !last) begin
      if (held_cnt == HELD_NONE) begin
        held_bytes = {b, 8'h00};
        held_cnt   = HELD_ONE;
      end else begin
        held_bytes[7:0] = b;
        held_cnt        = HELD_TWO;
      end
      return;
    end
    case (held_cnt)
      HELD_NONE: begin
        grp    = {b, 16'h0000};
        n_data = 2;
      end
      HELD_ONE: begin
        grp    = {held_bytes[15:8], b, 8'h00};
        n_data = 3;
      end
      default: begin
        grp    = {held_bytes, b};
        n_data = 4;
      end
    endcase
    for (int k = 0; k < 4; k++) begin
      c.ch       = (k < n_data) ? B64_ALPHABET[grp[23 - 6 * k -: 6]] : CHAR_PAD;
      c.grp_last = (k == SLOT_LAST);
      c.msg_done = (k == SLOT_LAST) && last;
      expected_chars.push_back(c);
    end
    held_cnt   = HELD_NONE;
    held_bytes = 16'h0000;
  endfunction

  // Sender: present queued words, idle in bursts, hold while stalled
  always @(posedge clk) begin
    msg_word_t w;
    if (rst) begin
      in_valid     <= 1'b0;
      tx_idle_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        encode_byte(data_byte, msg_end);
      end
      if (in_valid && in_stall) begin
        // hold the stalled word
      end else if (tx_idle_left != 0) begin
        in_valid     <= 1'b0;
        tx_idle_left <= tx_idle_left - 1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        in_valid     <= 1'b0;
        tx_idle_left <= $urandom_range(0, 13);
      end else if (tx_words.size() != 0) begin
        w = tx_words.pop_front();
        in_valid  <= 1'b1;
        data_byte <= w.data;
        msg_end   <= w.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold to back the block up
  always @(posedge clk) begin
    if (rst) begin
      out_stall      <= 1'b0;
      rx_idle_left   <= 0;
      long_hold_left <= 0;
      long_hold_done <= 1'b0;
    end else if (long_hold_left != 0) begin
      out_stall      <= 1'b1;
      long_hold_left <= long_hold_left - 1;
    end else if (!long_hold_done && chars_seen >= LONG_HOLD_AT) begin
      out_stall      <= 1'b1;
      long_hold_left <= LONG_HOLD_CYCLES;
      long_hold_done <= 1'b1;
    end else if (rx_idle_left != 0) begin
      out_stall    <= 1'b1;
      rx_idle_left <= rx_idle_left - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_stall    <= 1'b1;
      rx_idle_left <= $urandom_range(0, 13);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Check each accepted character against the oldest expectation
  always @(posedge clk) begin
    b64_char_t e;
    if (!rst && out_valid && !out_stall) begin
      chars_seen <= chars_seen + 1;
      if (expected_chars.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10)
          $display("unexpected char %h last=%b done=%b", out_char, group_last,
                   message_done);
      end else begin
        e = expected_chars.pop_front();
        if (out_char !== e.ch || group_last !== e.grp_last ||
            message_done !== e.msg_done) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("char %0d: expected %h/%b/%b got %h/%b/%b", chars_seen,
                     e.ch, e.grp_last, e.msg_done, out_char, group_last,
                     message_done);
        end
      end
    end
  end

  task automatic push_word(input logic [7:0] b, input logic last);
    msg_word_t w;
    w.data = b;
    w.last = last;
    tx_words.push_back(w);
  endtask

  // Whole messages with random content, mostly short, some long
  task automatic push_random_messages(input int n_bytes);
    int         added;
    int         len;
    logic [7:0] b;
    added = 0;
    while (added < n_bytes) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 9);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 7))
          0:       b = 8'h00;
          1:       b = 8'hFF;
          default: b = 8'($urandom_range(0, 255));
        endcase
        push_word(b, i == len - 1);
      end
      added += len;
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (tx_words.size() != 0 || in_valid || expected_chars.size() != 0);
  endtask

  // Directed messages: {last, byte}
  logic [8:0] directed_words[25] = '{
    {1'b1, 8'h00},
    {1'b1, 8'hFF},
    {1'b0, 8'hFF}, {1'b1, 8'hFF},
    {1'b0, 8'hFB}, {1'b0, 8'hEF}, {1'b1, 8'hBE},
    {1'b0, 8'hFF}, {1'b0, 8'hFF}, {1'b1, 8'hFF},
    {1'b0, 8'h00}, {1'b0, 8'h00}, {1'b1, 8'h00},
    {1'b0, 8'h4D}, {1'b0, 8'h61}, {1'b0, 8'h6E}, {1'b1, 8'h4D},
    {1'b0, 8'h01}, {1'b0, 8'h02}, {1'b0, 8'h03}, {1'b0, 8'h04}, {1'b1, 8'h05},
    {1'b0, 8'h80}, {1'b0, 8'h7F}, {1'b1, 8'h10}
  };

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_words[i])
      push_word(directed_words[i][7:0], directed_words[i][8]);
    wait_idle();

    // Keep the queue full so the long receiver hold backs up the input
    push_random_messages(170);
    wait_idle();

    push_random_messages(60);
    wait_idle();

    // Closing stretch with no idling on either side
    quiet = 1'b1;
    push_random_messages(60);
    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("base64_stream_encoder regression: pass");
    end else begin
      $display("base64_stream_encoder regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("base64_stream_encoder regression: fail");
    $finish;
  end

endmodule

/* files.f */
rtl/b64enc_pkg.sv
rtl/b64enc_front.sv
rtl/b64enc_queue.sv
rtl/b64enc_back.sv
rtl/base64_stream_encoder.sv
tb/tb_top.sv
